/* hw/rtl/gpu_warp_register_scoreboard_core_macros.svh */
// Assertion macros shared by the warp register scoreboard RTL.
`ifndef GPU_WARP_REGISTER_SCOREBOARD_CORE_MACROS_SVH
`define GPU_WARP_REGISTER_SCOREBOARD_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GWRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gwrs: assertion failed");

// Next-cycle implication, disabled during reset.
`define GWRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwrs: assertion failed");

`endif

/* hw/rtl/gwrs_pkg.sv */
// Shared constants, command codes and types of the warp register scoreboard.
package gwrs_pkg;

   // Sizes of the scoreboard
   localparam int WARPS     = 64;
   localparam int REGS      = 256;
   localparam int DEST_REGS = 4;
   localparam int NUM_DEST  = (DEST_REGS < 4) ? DEST_REGS : 4;

   // Field widths
   localparam int CMD_W  = 2;
   localparam int WARP_W = 6;
   localparam int REG_W  = 8;

   // Index widths into the row memory and into one row
   localparam int WARP_IDX_W = (WARPS > 1) ? $clog2(WARPS) : 1;
   localparam int REG_IDX_W  = $clog2(REGS);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

   typedef logic [WARP_IDX_W-1:0] warp_idx_type;
   typedef logic [REG_IDX_W-1:0]  reg_idx_type;
   typedef logic [REGS-1:0]       row_type;

   // One row of scoreboard state: long-op marks over reserved marks
   typedef struct packed {
      row_type lop;
      row_type res;
   } entry_type;

   // One request transaction
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WARP_W-1:0] warp;
      logic [REG_W-1:0]  reg0;
      logic [REG_W-1:0]  reg1;
      logic [REG_W-1:0]  reg2;
      logic [REG_W-1:0]  reg3;
      logic [REG_W-1:0]  pred_reg;
      logic [REG_W-1:0]  addr_reg_a;
      logic [REG_W-1:0]  addr_reg_b;
      logic              is_load;
   } item_type;

   // One response transaction
   typedef struct packed {
      logic collision;
      logic long_op;
      logic error;
   } result_type;

endpackage

/* hw/rtl/gwrs_if.sv */
// Request and response channel interfaces of the warp register scoreboard.
interface gwrs_req_if;
   logic                         valid;
   logic                         ready;
   logic [gwrs_pkg::CMD_W-1:0]   cmd;
   logic [gwrs_pkg::WARP_W-1:0]  warp;
   logic [gwrs_pkg::REG_W-1:0]   reg0;
   logic [gwrs_pkg::REG_W-1:0]   reg1;
   logic [gwrs_pkg::REG_W-1:0]   reg2;
   logic [gwrs_pkg::REG_W-1:0]   reg3;
   logic [gwrs_pkg::REG_W-1:0]   pred_reg;
   logic [gwrs_pkg::REG_W-1:0]   addr_reg_a;
   logic [gwrs_pkg::REG_W-1:0]   addr_reg_b;
   logic                         is_load;

   modport source (
      output valid, cmd, warp, reg0, reg1, reg2, reg3, pred_reg, addr_reg_a, addr_reg_b,
      output is_load,
      input  ready
   );
   modport sink (
      input  valid, cmd, warp, reg0, reg1, reg2, reg3, pred_reg, addr_reg_a, addr_reg_b,
      input  is_load,
      output ready
   );
endinterface

interface gwrs_rsp_if;
   logic valid;
   logic ready;
   logic collision;
   logic long_op;
   logic error;

   modport source (output valid, collision, long_op, error, input ready);
   modport sink   (input valid, collision, long_op, error, output ready);
endinterface

/* hw/rtl/gwrs_row_update.sv */
// Read-modify-write logic for one scoreboard row and the response of one transaction.
module gwrs_row_update (
   input  gwrs_pkg::item_type   item,
   input  gwrs_pkg::entry_type  old_row,
   output gwrs_pkg::entry_type  new_row,
   output logic                 wr_en,
   output gwrs_pkg::result_type result
);

   // Register 0 and registers past the file size name nothing
   function automatic logic reg_ok(input logic [gwrs_pkg::REG_W-1:0] r);
      return (r != '0) && (32'(r) < 32'(gwrs_pkg::REGS));
   endfunction

   function automatic logic bit_at(input gwrs_pkg::row_type row,
                                   input logic [gwrs_pkg::REG_W-1:0] r);
      return reg_ok(r) && row[gwrs_pkg::reg_idx_type'(r)];
   endfunction

   function automatic gwrs_pkg::row_type reg_mask(input logic [gwrs_pkg::REG_W-1:0] r);
      gwrs_pkg::row_type m;
      m = '0;
      if (reg_ok(r)) begin
         m[gwrs_pkg::reg_idx_type'(r)] = 1'b1;
      end
      return m;
   endfunction

   logic [3:0][gwrs_pkg::REG_W-1:0] dst;
   gwrs_pkg::row_type               dst_mask;
   logic                            dst_hit;
   logic                            side_hit;
   logic                            warp_ok;

   assign dst     = {item.reg3, item.reg2, item.reg1, item.reg0};
   assign warp_ok = 32'(item.warp) < 32'(gwrs_pkg::WARPS);

   // Destination mask and whether any destination is already reserved.
   // A duplicate sees the same old bit as its first copy, so no extra error.
   always_comb begin
      dst_mask = '0;
      dst_hit  = 1'b0;
      for (int i = 0; i < gwrs_pkg::NUM_DEST; i++) begin
         dst_mask = dst_mask | reg_mask(dst[i]);
         dst_hit  = dst_hit | bit_at(old_row.res, dst[i]);
      end
   end

   assign side_hit = bit_at(old_row.res, item.pred_reg)
                   | bit_at(old_row.res, item.addr_reg_a)
                   | bit_at(old_row.res, item.addr_reg_b);

   // Row update and response per command
   always_comb begin
      new_row          = old_row;
      wr_en            = 1'b0;
      result.collision = 1'b0;
      result.long_op   = 1'b0;
      result.error     = 1'b0;
      if (warp_ok) begin
         case (item.cmd)
            gwrs_pkg::CMD_RESERVE: begin
               wr_en       = 1'b1;
               new_row.res = old_row.res | dst_mask;
               if (item.is_load) begin
                  new_row.lop = old_row.lop | dst_mask;
               end
               result.error = dst_hit;
            end
            gwrs_pkg::CMD_RELEASE: begin
               wr_en       = 1'b1;
               new_row.res = old_row.res & ~dst_mask;
               new_row.lop = old_row.lop & ~dst_mask;
            end
            gwrs_pkg::CMD_CHECK: begin
               result.collision = dst_hit | side_hit;
            end
            gwrs_pkg::CMD_QUERY: begin
               result.long_op = bit_at(old_row.lop, item.reg0);
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/gpu_warp_register_scoreboard_core.sv */
// Top level of the per-warp GPU register scoreboard.
// Keeps a reserved mark and a long-op mark for every register of every warp and serves
// reserve, release, collision-check and long-op query transactions. It takes one
// transaction per cycle while the response side does not stall; a transaction waits in
// stage 1 with its row read, then its response goes to the response register, which lets
// a new transaction enter while a response waits. The rate is set by the row memory:
// each transaction does one read-modify-write of its warp's row (read at acceptance,
// written back when stage 1 advances), and a write-back is forwarded to a following
// transaction on the same warp. Rows come out of reset as all clear through one valid
// flop per warp, so there is no clearing pass and the block is ready right after reset.
`include "gpu_warp_register_scoreboard_core_macros.svh"

module gpu_warp_register_scoreboard_core (
   input logic        clock,
   input logic        reset,
   gwrs_req_if.sink   req_chan,
   gwrs_rsp_if.source rsp_chan
);

   gwrs_pkg::item_type     req_item;
   gwrs_pkg::warp_idx_type req_idx;
   gwrs_pkg::warp_idx_type p1_idx;
   logic                   req_accept;
   logic                   p1_adv;
   logic                   wr_en;
   logic                   upd_wr;
   logic                   fwd_in;
   logic                   p1_upd_cmd;
   logic                   fwd_match;
   gwrs_pkg::entry_type    old_row;
   gwrs_pkg::entry_type    new_row;
   gwrs_pkg::result_type   upd_result;

   // Row memory, one entry per warp
   gwrs_pkg::entry_type    row_mem [gwrs_pkg::WARPS];

   logic [gwrs_pkg::WARPS-1:0] row_vld_ff, row_vld_in;
   gwrs_pkg::entry_type        rd_data_ff;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_fwd_ff, rd_fwd_in;
   gwrs_pkg::entry_type        wb_row_ff, wb_row_in;
   gwrs_pkg::warp_idx_type     wb_idx_ff, wb_idx_in;
   gwrs_pkg::item_type         p1_item_ff, p1_item_in;
   logic                       p1_vld_ff, p1_vld_in;
   gwrs_pkg::result_type       rsp_data_ff, rsp_data_in;
   logic                       rsp_vld_ff, rsp_vld_in;

   // Request payload
   assign req_item.cmd        = req_chan.cmd;
   assign req_item.warp       = req_chan.warp;
   assign req_item.reg0       = req_chan.reg0;
   assign req_item.reg1       = req_chan.reg1;
   assign req_item.reg2       = req_chan.reg2;
   assign req_item.reg3       = req_chan.reg3;
   assign req_item.pred_reg   = req_chan.pred_reg;
   assign req_item.addr_reg_a = req_chan.addr_reg_a;
   assign req_item.addr_reg_b = req_chan.addr_reg_b;
   assign req_item.is_load    = req_chan.is_load;

   // Handshake: stage 1 moves on when the response register is free or drains
   assign p1_adv         = p1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !p1_vld_ff || p1_adv;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign req_idx = gwrs_pkg::warp_idx_type'(req_chan.warp);
   assign p1_idx  = gwrs_pkg::warp_idx_type'(p1_item_ff.warp);

   // Old row: forwarded write-back, stored row, or clear when never written
   always_comb begin
      if (rd_fwd_ff) begin
         old_row = wb_row_ff;
      end else if (rd_vld_ff) begin
         old_row = rd_data_ff;
      end else begin
         old_row = '0;
      end
   end

   gwrs_row_update u_row_update (
      .item    (p1_item_ff),
      .old_row (old_row),
      .new_row (new_row),
      .wr_en   (upd_wr),
      .result  (upd_result)
   );

   assign wr_en  = p1_adv && upd_wr;
   assign fwd_in = wr_en && (p1_idx == req_idx);

   // Next-state logic
   always_comb begin
      row_vld_in  = row_vld_ff;
      rd_vld_in   = rd_vld_ff;
      rd_fwd_in   = rd_fwd_ff;
      wb_row_in   = wb_row_ff;
      wb_idx_in   = wb_idx_ff;
      p1_item_in  = p1_item_ff;
      p1_vld_in   = p1_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff;

      if (wr_en) begin
         row_vld_in[p1_idx] = 1'b1;
         wb_row_in          = new_row;
         wb_idx_in          = p1_idx;
      end

      if (req_accept) begin
         rd_vld_in  = row_vld_ff[req_idx];
         rd_fwd_in  = fwd_in;
         p1_item_in = req_item;
         p1_vld_in  = 1'b1;
      end else if (p1_adv) begin
         p1_vld_in = 1'b0;
      end

      if (p1_adv) begin
         rsp_data_in = upd_result;
         rsp_vld_in  = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         rd_fwd_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         row_vld_ff <= row_vld_in;
         rd_vld_ff  <= rd_vld_in;
         rd_fwd_ff  <= rd_fwd_in;
         p1_vld_ff  <= p1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wb_row_ff   <= wb_row_in;
      wb_idx_ff   <= wb_idx_in;
      p1_item_ff  <= p1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row memory: read at acceptance, write-back from stage 1
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= row_mem[req_idx];
      end
      if (wr_en) begin
         row_mem[p1_idx] <= new_row;
      end
   end

   // Response port
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.collision = rsp_data_ff.collision;
   assign rsp_chan.long_op   = rsp_data_ff.long_op;
   assign rsp_chan.error     = rsp_data_ff.error;

   // Terms used by the assertions
   assign p1_upd_cmd = (p1_item_ff.cmd == gwrs_pkg::CMD_RESERVE)
                     || (p1_item_ff.cmd == gwrs_pkg::CMD_RELEASE);
   assign fwd_match  = p1_vld_ff && rd_fwd_ff && (wb_idx_ff == p1_idx);

   // Assertions
   `GWRS_ASSERT_IMPL(a_rsp_one_flag, clock, reset, rsp_vld_ff, $onehot0(rsp_data_ff))
   `GWRS_ASSERT_IMPL(a_wr_only_update, clock, reset, wr_en, p1_upd_cmd)
   `GWRS_ASSERT_NEXT(a_wr_marks_row, clock, reset, wr_en, row_vld_ff[wb_idx_ff])
   `GWRS_ASSERT_NEXT(a_fwd_same_warp, clock, reset, req_accept && fwd_in, fwd_match)

endmodule

/* bench/tb_gpu_warp_register_scoreboard_core.sv */
// Self-checking bench for the warp register scoreboard: directed and random traffic, stalls, flag checks.
module tb_gpu_warp_register_scoreboard_core;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct {
      gwrs_pkg::item_type item;
      bit                 drain;   // hold this one back until every response is in
   } issue_slot_type;

   logic clock;
   logic reset;

   gwrs_req_if req_chan ();
   gwrs_rsp_if rsp_chan ();

   gpu_warp_register_scoreboard_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Scoreboard image kept by the bench
   gwrs_pkg::row_type reserved_rows [gwrs_pkg::WARPS];
   gwrs_pkg::row_type long_op_rows  [gwrs_pkg::WARPS];

   issue_slot_type       issue_q [$];
   gwrs_pkg::result_type predicted_flags_q [$];

   int          send_gap;
   int          sink_stall;
   int unsigned sent_total;
   int unsigned recv_total;
   int unsigned cycle_count;
   int          fail_count;

   // Clock, plus known values on every block input from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = '0;
      req_chan.warp = '0;
      req_chan.reg0 = '0;
      req_chan.reg1 = '0;
      req_chan.reg2 = '0;
      req_chan.reg3 = '0;
      req_chan.pred_reg = '0;
      req_chan.addr_reg_a = '0;
      req_chan.addr_reg_b = '0;
      req_chan.is_load = 1'b0;
      rsp_chan.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   // Single reset at start of run
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic bit reg_named(logic [gwrs_pkg::REG_W-1:0] r);
      return (r != '0) && (int'(r) < gwrs_pkg::REGS);
   endfunction

   // Apply one transaction to the image and return the flags it must produce
   function automatic gwrs_pkg::result_type scoreboard_apply(gwrs_pkg::item_type it);
      logic [gwrs_pkg::REG_W-1:0] dst [4];
      gwrs_pkg::result_type       flags;
      bit                         dup;
      int                         i;
      int                         j;
      flags = '0;
      dst[0] = it.reg0;
      dst[1] = it.reg1;
      dst[2] = it.reg2;
      dst[3] = it.reg3;
      if (int'(it.warp) < gwrs_pkg::WARPS) begin
         case (it.cmd)
            gwrs_pkg::CMD_RESERVE: begin
               for (i = 0; i < gwrs_pkg::NUM_DEST; i++) begin
                  if (reg_named(dst[i])) begin
                     dup = 1'b0;
                     for (j = 0; j < i; j++)
                        if (dst[j] == dst[i]) dup = 1'b1;
                     if (!dup) begin
                        if (reserved_rows[it.warp][dst[i]]) flags.error = 1'b1;
                        reserved_rows[it.warp][dst[i]] = 1'b1;
                     end
                  end
               end
               if (it.is_load)
                  for (i = 0; i < gwrs_pkg::NUM_DEST; i++)
                     if (reg_named(dst[i])) long_op_rows[it.warp][dst[i]] = 1'b1;
            end
            gwrs_pkg::CMD_RELEASE: begin
               for (i = 0; i < gwrs_pkg::NUM_DEST; i++)
                  if (reg_named(dst[i])) begin
                     reserved_rows[it.warp][dst[i]] = 1'b0;
                     long_op_rows[it.warp][dst[i]] = 1'b0;
                  end
            end
            gwrs_pkg::CMD_CHECK: begin
               if (reg_named(it.pred_reg) && reserved_rows[it.warp][it.pred_reg])
                  flags.collision = 1'b1;
               if (reg_named(it.addr_reg_a) && reserved_rows[it.warp][it.addr_reg_a])
                  flags.collision = 1'b1;
               if (reg_named(it.addr_reg_b) && reserved_rows[it.warp][it.addr_reg_b])
                  flags.collision = 1'b1;
               for (i = 0; i < gwrs_pkg::NUM_DEST; i++)
                  if (reg_named(dst[i]) && reserved_rows[it.warp][dst[i]])
                     flags.collision = 1'b1;
            end
            default: begin
               if (reg_named(dst[0]) && long_op_rows[it.warp][dst[0]])
                  flags.long_op = 1'b1;
            end
         endcase
      end
      return flags;
   endfunction

   task automatic note_failure(string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // Stretches with no idling on either side
   function automatic bit calm_stretch();
      return (cycle_count % 3000) < 400;
   endfunction

   // Idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Request driver
   always @(posedge clock) begin
      bit accept_now;
      int outstanding;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
         sent_total <= 0;
      end else begin
         accept_now = req_chan.valid && req_chan.ready;
         if (accept_now) begin
            predicted_flags_q.push_back(scoreboard_apply(issue_q[0].item));
            void'(issue_q.pop_front());
            sent_total <= sent_total + 1;
            if (!calm_stretch() && $urandom_range(0, 99) < 40) send_gap = pick_gap();
         end
         outstanding = int'(sent_total) + int'(accept_now) - int'(recv_total)
                       - int'(rsp_chan.valid && rsp_chan.ready);
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (issue_q.size() > 0 && !(issue_q[0].drain && outstanding != 0)) begin
               req_chan.valid <= 1'b1;
               req_chan.cmd <= issue_q[0].item.cmd;
               req_chan.warp <= issue_q[0].item.warp;
               req_chan.reg0 <= issue_q[0].item.reg0;
               req_chan.reg1 <= issue_q[0].item.reg1;
               req_chan.reg2 <= issue_q[0].item.reg2;
               req_chan.reg3 <= issue_q[0].item.reg3;
               req_chan.pred_reg <= issue_q[0].item.pred_reg;
               req_chan.addr_reg_a <= issue_q[0].item.addr_reg_a;
               req_chan.addr_reg_b <= issue_q[0].item.addr_reg_b;
               req_chan.is_load <= issue_q[0].item.is_load;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready stalls
   always @(posedge clock) begin
      gwrs_pkg::result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_stall = 0;
         recv_total <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            recv_total <= recv_total + 1;
            if (predicted_flags_q.size() == 0) begin
               note_failure("response with no transaction pending");
            end else begin
               want = predicted_flags_q.pop_front();
               if (rsp_chan.collision !== want.collision)
                  note_failure($sformatf("collision got %b want %b",
                                         rsp_chan.collision, want.collision));
               if (rsp_chan.long_op !== want.long_op)
                  note_failure($sformatf("long_op got %b want %b",
                                         rsp_chan.long_op, want.long_op));
               if (rsp_chan.error !== want.error)
                  note_failure($sformatf("error got %b want %b",
                                         rsp_chan.error, want.error));
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm_stretch() && $urandom_range(0, 5) == 0) begin
            sink_stall = pick_gap() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic gwrs_pkg::item_type mk_item(logic [gwrs_pkg::CMD_W-1:0] cmd, int warp,
                                                  int r0, int r1, int r2, int r3,
                                                  int pred, int ra, int rb, bit load);
      gwrs_pkg::item_type it;
      it.cmd = cmd;
      it.warp = gwrs_pkg::WARP_W'(warp);
      it.reg0 = gwrs_pkg::REG_W'(r0);
      it.reg1 = gwrs_pkg::REG_W'(r1);
      it.reg2 = gwrs_pkg::REG_W'(r2);
      it.reg3 = gwrs_pkg::REG_W'(r3);
      it.pred_reg = gwrs_pkg::REG_W'(pred);
      it.addr_reg_a = gwrs_pkg::REG_W'(ra);
      it.addr_reg_b = gwrs_pkg::REG_W'(rb);
      it.is_load = load;
      return it;
   endfunction

   task automatic push_item(gwrs_pkg::item_type it, bit drain);
      issue_slot_type s;
      s.item = it;
      s.drain = drain;
      issue_q.push_back(s);
   endtask

   // Register from a small pool so that marks pile up and collide
   function automatic int pick_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      else if (r < 85) return $urandom_range(1, 10);
      else if (r < 95) return $urandom_range(250, 255);
      else return $urandom_range(0, 255);
   endfunction

   function automatic int pick_warp();
      int hot [4];
      hot = '{0, 17, 42, 63};
      return hot[$urandom_range(0, 3)];
   endfunction

   function automatic logic [gwrs_pkg::CMD_W-1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return gwrs_pkg::CMD_RESERVE;
      else if (r < 55) return gwrs_pkg::CMD_RELEASE;
      else if (r < 85) return gwrs_pkg::CMD_CHECK;
      else return gwrs_pkg::CMD_QUERY;
   endfunction

   function automatic bit pick_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Stimulus and end of run
   initial begin
      int made;
      int w;
      int r0;
      int r1;
      int r2;
      int r3;
      int mode;
      gwrs_pkg::item_type it;
      for (w = 0; w < gwrs_pkg::WARPS; w++) begin
         reserved_rows[w] = '0;
         long_op_rows[w] = '0;
      end
      fail_count = 0;
      cycle_count = 0;

      // Directed: empty rows, duplicates, register zero, top register, re-reserve
      push_item(mk_item(gwrs_pkg::CMD_QUERY,   0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 1, 2, 3, 4, 5, 6, 7, 1'b1), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RESERVE, 0, 1, 1, 0, 255, 0, 0, 0, 1'b1), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RESERVE, 0, 2, 1, 2, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 0, 0, 0, 0, 2, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,  63, 1, 2, 255, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,   0, 1, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,   0, 2, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,   0, 255, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RELEASE, 0, 1, 7, 0, 0, 0, 0, 0, 1'b1), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 0, 0, 0, 0, 0, 0, 1, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 0, 0, 0, 0, 0, 255, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,   0, 1, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RESERVE, 63, 255, 254, 253, 252, 255, 255, 255, 1'b1),
                1'b1);
      push_item(mk_item(gwrs_pkg::CMD_RESERVE, 63, 252, 251, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,  63, 255, 255, 255, 255, 255, 255, 255, 1'b1),
                1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,  63, 0, 0, 0, 0, 0, 0, 251, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,  63, 251, 255, 255, 255, 255, 255, 255, 1'b1),
                1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RELEASE, 63, 255, 254, 253, 252, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_QUERY,  63, 255, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,  63, 255, 254, 253, 252, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_RELEASE, 0, 255, 2, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      push_item(mk_item(gwrs_pkg::CMD_CHECK,   0, 1, 2, 255, 0, 1, 2, 255, 1'b0), 1'b0);

      // Random: issue-style sequences on hot warps, singles, and raw noise
      made = 0;
      while (made < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 99);
         if (mode < 45) begin
            w = pick_warp();
            r0 = pick_reg();
            r1 = pick_reg();
            r2 = pick_reg();
            r3 = pick_reg();
            push_item(mk_item(gwrs_pkg::CMD_RESERVE, w, r0, r1, r2, r3, 0, 0, 0, pick_bit()),
                      (made % 400) == 399);
            push_item(mk_item(gwrs_pkg::CMD_CHECK, w, pick_reg(), pick_reg(), pick_reg(),
                              pick_reg(), r0, pick_reg(), pick_reg(), pick_bit()), 1'b0);
            push_item(mk_item(gwrs_pkg::CMD_QUERY, w, (pick_bit() ? r0 : r1), pick_reg(),
                              pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                              pick_bit()), 1'b0);
            made += 3;
            if (pick_bit()) begin
               push_item(mk_item(gwrs_pkg::CMD_RELEASE, w, r0, r1, r2, r3, 0, 0, 0,
                                 pick_bit()), 1'b0);
               made++;
            end
         end else if (mode < 80) begin
            push_item(mk_item(pick_cmd(), pick_warp(), pick_reg(), pick_reg(), pick_reg(),
                              pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                              pick_bit()), 1'b0);
            made++;
         end else begin
            it = gwrs_pkg::item_type'({$urandom(), $urandom(), $urandom()});
            push_item(it, 1'b0);
            made++;
         end
      end

      // Drain and settle
      @(negedge clock);
      while (reset) @(negedge clock);
      while (issue_q.size() != 0 || predicted_flags_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (predicted_flags_q.size() != 0)
         note_failure($sformatf("%0d responses never arrived", predicted_flags_q.size()));
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
